// ----- design/vca_pkg.sv -----
// vca_pkg: field widths, request codes and the structs shared by the voice
// allocator top level and its voice cells. No dependencies.
`default_nettype none

package vca_pkg;

	localparam int KIND_W   = 2;
	localparam int ORIGIN_W = 16;
	localparam int SECTOR_W = 12;
	localparam int SOUND_W  = 8;
	localparam int PRIO_W   = 8;
	localparam int VOICE_W  = 3;
	localparam int CFG_W    = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STOP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	// request held by the top level and seen by every cell
	typedef struct packed {
		logic                do_stop;
		logic                do_alloc;
		logic                rel;
		logic [VOICE_W-1:0]  rel_idx;
		logic [SOUND_W-1:0]  sound;
		logic [ORIGIN_W-1:0] origin;
		logic                has_sec;
		logic [SECTOR_W-1:0] sector;
		logic [PRIO_W-1:0]   pri;
	} req_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic               vld;
		logic               a_found;
		logic [VOICE_W-1:0] a_idx;
		logic               g_found;
		logic               g_reuse;
		logic [VOICE_W-1:0] g_idx;
		logic               s_found;
		logic [VOICE_W-1:0] s_idx;
	} token_t;

	// final write, one cycle, after the token leaves the chain
	typedef struct packed {
		logic wr;
		logic sel_alloc;
		logic sel_steal;
	} commit_t;

endpackage

`default_nettype wire

// ----- design/vca_cell.sv -----
// vca_cell: one voice slot of the allocator chain; holds the voice entry,
// checks the passing search token and forwards it. Depends on vca_pkg.
`default_nettype none

module vca_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [vca_pkg::CFG_W-1:0]  cfg,
	input  vca_pkg::req_t              req,
	input  vca_pkg::commit_t           cm,
	input  vca_pkg::token_t            tok_in,
	output vca_pkg::token_t            tok_out
);
	import vca_pkg::*;

	localparam logic [VOICE_W-1:0] SELF = VOICE_W'(IDX);

	logic [SOUND_W-1:0]  sound_q;
	logic [ORIGIN_W-1:0] origin_q;
	logic                has_sec_q;
	logic [SECTOR_W-1:0] sector_q;
	logic [PRIO_W-1:0]   pri_q;
	logic                pick_g_q;
	logic                pick_s_q;
	token_t              tok_q;
	token_t              tok_nxt;

	logic en;
	logic act;
	logic busy;
	logic org_eq;
	logic stop_hit;
	logic eff_free;
	logic alloc_hit;
	logic steal_hit;
	logic rel_hit;
	logic take;

	always_comb begin
		en        = int'(cfg) > IDX;
		act       = tok_in.vld && en;
		busy      = sound_q != '0;
		org_eq    = origin_q == req.origin;
		stop_hit  = act && req.do_stop && !tok_in.a_found && busy &&
			(req.has_sec ? (has_sec_q && sector_q == req.sector) : org_eq);
		eff_free  = !busy || stop_hit;
		alloc_hit = act && req.do_alloc && !tok_in.g_found &&
			(eff_free || (req.origin != '0 && org_eq));
		steal_hit = act && req.do_alloc && !tok_in.s_found && (pri_q >= req.pri);
		rel_hit   = req.rel && (int'(req.rel_idx) == IDX);
		take      = (cm.sel_alloc && pick_g_q) || (cm.sel_steal && pick_s_q);

		tok_nxt = tok_in;
		if (stop_hit) begin
			tok_nxt.a_found = 1'b1;
			tok_nxt.a_idx   = SELF;
		end
		if (alloc_hit) begin
			tok_nxt.g_found = 1'b1;
			tok_nxt.g_reuse = !eff_free;
			tok_nxt.g_idx   = SELF;
		end
		if (steal_hit) begin
			tok_nxt.s_found = 1'b1;
			tok_nxt.s_idx   = SELF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_q   <= '0;
			origin_q  <= '0;
			has_sec_q <= 1'b0;
			sector_q  <= '0;
			pri_q     <= '0;
			pick_g_q  <= 1'b0;
			pick_s_q  <= 1'b0;
			tok_q     <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (tok_in.vld) begin
				pick_g_q <= alloc_hit;
				pick_s_q <= steal_hit;
			end
			if (stop_hit) begin
				sound_q <= '0;
			end
			if (cm.wr && take) begin
				sound_q   <= req.sound;
				origin_q  <= req.origin;
				has_sec_q <= req.has_sec;
				sector_q  <= req.sector;
				pri_q     <= req.pri;
			end
			if (cm.wr && rel_hit) begin
				sound_q <= '0;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ----- design/voice_channel_allocator.sv -----
// voice_channel_allocator: top level; request and result registers, control
// sequencer and the chain of vca_cell voice slots. Depends on vca_pkg, vca_cell.
//
// Usage:
//  - input channel in_valid/in_ready carries one request beat (start, stop or
//    release); output channel out_valid/out_ready returns exactly one result
//    beat per request, in order.
//  - cfg_we/cfg_wdata write voices_in_use (voices searched, 0 to 15, clamped
//    to MAX_VOICES); write only while no request is in flight.
//  - a request sends a search token down the row of MAX_VOICES cells, one
//    cell per cycle; each cell stops or selects its own voice as the token
//    passes. The chosen voice is written once the output register is free.
//  - a request passes start_q, the cell registers and fin_q to out_valid.
//  - a new request is taken only after the previous one has walked the cell
//    row and been committed; one request is in flight at a time.
//  - a result waiting on out_ready does not block the next request; the
//    following result waits at the end of the chain until the output
//    register is free.
//  - reset frees all voices and sets voices_in_use to 8.
`default_nettype none

module voice_channel_allocator #(
	parameter int MAX_VOICES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vca_pkg::KIND_W-1:0]    kind,
	input  logic [vca_pkg::ORIGIN_W-1:0]  origin_ref,
	input  logic                          sector_given,
	input  logic [vca_pkg::SECTOR_W-1:0]  sector_num,
	input  logic [vca_pkg::SOUND_W-1:0]   sound_id,
	input  logic [vca_pkg::PRIO_W-1:0]    sound_priority,
	input  logic [vca_pkg::VOICE_W-1:0]   voice_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          granted,
	output logic [vca_pkg::VOICE_W-1:0]   voice,
	output logic                          stop_a_valid,
	output logic [vca_pkg::VOICE_W-1:0]   stop_a_voice,
	output logic                          stop_b_valid,
	output logic [vca_pkg::VOICE_W-1:0]   stop_b_voice,
	input  logic                          cfg_we,
	input  logic [vca_pkg::CFG_W-1:0]     cfg_wdata
);
	import vca_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

	state_t           state_q;
	req_t             req_q;
	logic             start_q;
	token_t           fin_q;
	logic [CFG_W-1:0] cfg_q;
	commit_t          commit;
	logic             commit_go;
	logic             start_req;
	token_t           tok [MAX_VOICES+1];
	logic [MAX_VOICES:0] tok_vld;

	always_comb begin
		tok[0]     = '0;
		tok[0].vld = start_q;
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_VOICES; gi++) begin : g_cell
			vca_cell #(.IDX(gi)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cfg    (cfg_q),
				.req    (req_q),
				.cm     (commit),
				.tok_in (tok[gi]),
				.tok_out(tok[gi+1])
			);
		end
		for (gi = 0; gi <= MAX_VOICES; gi++) begin : g_vld
			assign tok_vld[gi] = tok[gi].vld;
		end
	endgenerate

	assign in_ready  = state_q == ST_IDLE;
	assign start_req = (kind == KIND_START) && (sound_id != '0);
	assign commit_go = (state_q == ST_FIN) && (!out_valid || out_ready);

	always_comb begin
		commit.wr        = commit_go;
		commit.sel_alloc = fin_q.g_found;
		commit.sel_steal = !fin_q.g_found && fin_q.s_found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			req_q        <= '0;
			start_q      <= 1'b0;
			fin_q        <= '0;
			out_valid    <= 1'b0;
			granted      <= 1'b0;
			voice        <= '0;
			stop_a_valid <= 1'b0;
			stop_a_voice <= '0;
			stop_b_valid <= 1'b0;
			stop_b_voice <= '0;
		end else begin
			start_q <= (state_q == ST_IDLE) && in_valid;
			if (out_valid && out_ready && !commit_go) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q.do_alloc <= start_req;
						req_q.do_stop  <= start_req || (kind == KIND_STOP);
						req_q.rel      <= kind == KIND_RELEASE;
						req_q.rel_idx  <= voice_index;
						req_q.sound    <= sound_id;
						req_q.origin   <= origin_ref;
						req_q.has_sec  <= sector_given;
						req_q.sector   <= sector_given ? sector_num : '0;
						req_q.pri      <= sound_priority;
						state_q        <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tok[MAX_VOICES].vld) begin
						fin_q   <= tok[MAX_VOICES];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (commit_go) begin
						out_valid    <= 1'b1;
						granted      <= fin_q.g_found || fin_q.s_found;
						voice        <= fin_q.g_found ? fin_q.g_idx :
							(fin_q.s_found ? fin_q.s_idx : '0);
						stop_a_valid <= fin_q.a_found;
						stop_a_voice <= fin_q.a_found ? fin_q.a_idx : '0;
						stop_b_valid <= fin_q.g_found ? fin_q.g_reuse : fin_q.s_found;
						stop_b_voice <= fin_q.g_found ?
							(fin_q.g_reuse ? fin_q.g_idx : '0) :
							(fin_q.s_found ? fin_q.s_idx : '0);
						state_q      <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// at most one token walks the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one search token in the cell chain");

	// a new beat is taken only when the chain is empty
	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (tok_vld == '0 && !start_q))
		else $error("request accepted while a search is in flight");

	// a reuse or steal always comes with a grant
	a_steal_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stop_b_valid) |-> granted)
		else $error("stop_b reported without a granted voice");

	// a fresh result follows a finished search
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the final step");

endmodule

`default_nettype wire

// ----- tb/sv/voice_channel_allocator_test.sv -----
// voice_channel_allocator_test: self-checking bench for the voice allocator; a directed
// table, then random requests under several voices_in_use settings and handshake pacings.
// Depends on vca_pkg and voice_channel_allocator.
`timescale 1ns / 1ps

module voice_channel_allocator_test;

	localparam int MAX_VOICES  = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES  = 10;
	localparam logic [vca_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [vca_pkg::KIND_W-1:0]   kind;
		logic [vca_pkg::ORIGIN_W-1:0] origin;
		logic                         sec_given;
		logic [vca_pkg::SECTOR_W-1:0] sector;
		logic [vca_pkg::SOUND_W-1:0]  sound;
		logic [vca_pkg::PRIO_W-1:0]   prio;
		logic [vca_pkg::VOICE_W-1:0]  vidx;
	} sound_req_t;

	typedef struct packed {
		logic                        granted;
		logic [vca_pkg::VOICE_W-1:0] voice;
		logic                        a_valid;
		logic [vca_pkg::VOICE_W-1:0] a_voice;
		logic                        b_valid;
		logic [vca_pkg::VOICE_W-1:0] b_voice;
	} grant_t;

	typedef struct packed {
		bit         typed;
		grant_t     want;
		sound_req_t req;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [vca_pkg::KIND_W-1:0] kind = '0;
	logic [vca_pkg::ORIGIN_W-1:0] origin_ref = '0;
	logic sector_given = 1'b0;
	logic [vca_pkg::SECTOR_W-1:0] sector_num = '0;
	logic [vca_pkg::SOUND_W-1:0] sound_id = '0;
	logic [vca_pkg::PRIO_W-1:0] sound_priority = '0;
	logic [vca_pkg::VOICE_W-1:0] voice_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic granted;
	logic [vca_pkg::VOICE_W-1:0] voice;
	logic stop_a_valid;
	logic [vca_pkg::VOICE_W-1:0] stop_a_voice;
	logic stop_b_valid;
	logic [vca_pkg::VOICE_W-1:0] stop_b_voice;
	logic cfg_we = 1'b0;
	logic [vca_pkg::CFG_W-1:0] cfg_wdata = '0;

	// shadow of the voice table
	logic [vca_pkg::SOUND_W-1:0]  slot_sound [MAX_VOICES];
	logic [vca_pkg::ORIGIN_W-1:0] slot_origin [MAX_VOICES];
	logic                         slot_sectored [MAX_VOICES];
	logic [vca_pkg::SECTOR_W-1:0] slot_sector [MAX_VOICES];
	logic [vca_pkg::PRIO_W-1:0]   slot_prio [MAX_VOICES];
	logic [vca_pkg::CFG_W-1:0]    cfg_voices = vca_pkg::CFG_RESET;

	grant_t pending_grants[$];
	row_t directed_rows[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int failures = 0;
	int cycle_count = 0;
	int requests_sent = 0;
	int grants_made = 0;
	int reuse_or_steal = 0;
	int settings_written = 0;
	int cfg_plan[NUM_PHASES] = '{15, 1, 8, 0, -1, 8, 4, 8, -1, -2};
	int idle_plan[NUM_PHASES] = '{0, 61, 0, 32, 0, 61, 0, 32, 61, 0};
	int stall_plan[NUM_PHASES] = '{0, 0, 61, 32, 0, 0, 61, 32, 0, 61};
	int items_plan[NUM_PHASES] = '{200, 200, 200, 150, 200, 200, 200, 200, 200, 200};

	voice_channel_allocator #(
		.MAX_VOICES(MAX_VOICES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.origin_ref(origin_ref),
		.sector_given(sector_given),
		.sector_num(sector_num),
		.sound_id(sound_id),
		.sound_priority(sound_priority),
		.voice_index(voice_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted(granted),
		.voice(voice),
		.stop_a_valid(stop_a_valid),
		.stop_a_voice(stop_a_voice),
		.stop_b_valid(stop_b_valid),
		.stop_b_voice(stop_b_voice),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int search_span();
		return (cfg_voices > MAX_VOICES) ? MAX_VOICES : int'(cfg_voices);
	endfunction

	function automatic int stop_first(logic [vca_pkg::ORIGIN_W-1:0] org, logic sg,
			logic [vca_pkg::SECTOR_W-1:0] sec);
		int n;
		n = search_span();
		for (int i = 0; i < n; i++) begin
			if (slot_sound[i] != 0 &&
					(sg ? (slot_sectored[i] && slot_sector[i] == sec) : (slot_origin[i] == org))) begin
				slot_sound[i] = '0;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic grant_t allocate_voice(sound_req_t r);
		grant_t res;
		int a;
		int b;
		int g;
		int n;
		logic [vca_pkg::SECTOR_W-1:0] sec;
		res = '0;
		a = -1;
		b = -1;
		g = -1;
		n = search_span();
		sec = r.sec_given ? r.sector : '0;
		if (r.kind == vca_pkg::KIND_START && r.sound != 0) begin
			a = stop_first(r.origin, r.sec_given, sec);
			for (int i = 0; i < n; i++) begin
				if (slot_sound[i] == 0) begin
					g = i;
					break;
				end
				if (r.origin != 0 && slot_origin[i] == r.origin) begin
					g = i;
					b = i;
					break;
				end
			end
			if (g < 0) begin
				for (int i = 0; i < n; i++) begin
					if (slot_prio[i] >= r.prio) begin
						g = i;
						b = i;
						break;
					end
				end
			end
			if (g >= 0) begin
				slot_sound[g] = r.sound;
				slot_origin[g] = r.origin;
				slot_sectored[g] = r.sec_given;
				slot_sector[g] = sec;
				slot_prio[g] = r.prio;
			end
		end else if (r.kind == vca_pkg::KIND_STOP) begin
			a = stop_first(r.origin, r.sec_given, sec);
		end else if (r.kind == vca_pkg::KIND_RELEASE) begin
			slot_sound[r.vidx] = '0;
		end
		if (g >= 0) begin
			res.granted = 1'b1;
			res.voice = g[2:0];
		end
		if (a >= 0) begin
			res.a_valid = 1'b1;
			res.a_voice = a[2:0];
		end
		if (b >= 0) begin
			res.b_valid = 1'b1;
			res.b_voice = b[2:0];
		end
		return res;
	endfunction

	function automatic sound_req_t rq(logic [1:0] k, int org, bit sg, int sec, int sid, int pri,
			int vidx);
		sound_req_t r;
		r.kind = k;
		r.origin = org[15:0];
		r.sec_given = sg;
		r.sector = sec[11:0];
		r.sound = sid[7:0];
		r.prio = pri[7:0];
		r.vidx = vidx[2:0];
		return r;
	endfunction

	function automatic grant_t gw(bit g, int v, bit av, int a, bit bv, int b);
		grant_t w;
		w.granted = g;
		w.voice = v[2:0];
		w.a_valid = av;
		w.a_voice = a[2:0];
		w.b_valid = bv;
		w.b_voice = b[2:0];
		return w;
	endfunction

	function automatic void add_row(sound_req_t r, bit typed, grant_t w);
		row_t row;
		row.typed = typed;
		row.want = w;
		row.req = r;
		directed_rows.push_back(row);
	endfunction

	function automatic sound_req_t random_req();
		sound_req_t r;
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			r.kind = vca_pkg::KIND_START;
		else if (sel < 78)
			r.kind = vca_pkg::KIND_STOP;
		else if (sel < 95)
			r.kind = vca_pkg::KIND_RELEASE;
		else
			r.kind = KIND_UNUSED;
		r.origin = ($urandom_range(99) < 80) ? 16'($urandom_range(6)) :
			16'($urandom_range(65535));
		r.sec_given = ($urandom_range(99) < 30);
		r.sector = ($urandom_range(99) < 70) ? 12'($urandom_range(1, 4)) :
			12'($urandom_range(4095));
		r.sound = ($urandom_range(99) < 5) ? 8'd0 : 8'($urandom_range(1, 255));
		sel = $urandom_range(9);
		r.prio = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(255));
		r.vidx = 3'($urandom_range(7));
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		grant_t head;
		if (arst_n && out_valid && out_ready) begin
			if (pending_grants.size() == 0) begin
				$error("result beat with no request pending");
				failures++;
			end else begin
				head = pending_grants.pop_front();
				check_field("granted", head.granted, granted);
				check_field("voice", head.voice, voice);
				check_field("stop_a_valid", head.a_valid, stop_a_valid);
				check_field("stop_a_voice", head.a_voice, stop_a_voice);
				check_field("stop_b_valid", head.b_valid, stop_b_valid);
				check_field("stop_b_voice", head.b_voice, stop_b_voice);
			end
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_grants.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_request(sound_req_t r, bit typed, grant_t w);
		grant_t p;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= r.kind;
		origin_ref <= r.origin;
		sector_given <= r.sec_given;
		sector_num <= r.sector;
		sound_id <= r.sound;
		sound_priority <= r.prio;
		voice_index <= r.vidx;
		do @(posedge clk); while (!in_ready);
		p = allocate_voice(r);
		pending_grants.push_back(typed ? w : p);
		requests_sent++;
		if (p.granted)
			grants_made++;
		if (p.b_valid)
			reuse_or_steal++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_grants.size() != 0);
	endtask

	task automatic set_voices(logic [vca_pkg::CFG_W-1:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_voices = v;
		settings_written++;
	endtask

	initial begin
		int cfg;
		for (int i = 0; i < MAX_VOICES; i++) begin
			slot_sound[i] = '0;
			slot_origin[i] = '0;
			slot_sectored[i] = 1'b0;
			slot_sector[i] = '0;
			slot_prio[i] = '0;
		end

		// after reset, extremes, the special cases, then a full table to steal from
		add_row(rq(vca_pkg::KIND_START, 1, 0, 0, 5, 100, 0), 1, gw(1, 0, 0, 0, 0, 0));
		add_row(rq(vca_pkg::KIND_START, 16'hffff, 1, 12'hfff, 255, 255, 7), 1,
			gw(1, 1, 0, 0, 0, 0));
		add_row(rq(vca_pkg::KIND_START, 1, 0, 0, 7, 0, 0), 1, gw(1, 0, 1, 0, 0, 0));
		add_row(rq(vca_pkg::KIND_STOP, 16'hffff, 1, 12'hfff, 0, 0, 0), 1, gw(0, 0, 1, 1, 0, 0));
		add_row(rq(vca_pkg::KIND_START, 1, 0, 0, 0, 50, 0), 1, '0);
		add_row(rq(KIND_UNUSED, 16'hffff, 1, 12'hfff, 255, 255, 7), 1, '0);
		add_row(rq(vca_pkg::KIND_RELEASE, 0, 0, 0, 0, 0, 7), 1, '0);
		add_row(rq(vca_pkg::KIND_RELEASE, 0, 0, 0, 0, 0, 0), 1, '0);
		for (int i = 0; i < MAX_VOICES; i++)
			add_row(rq(vca_pkg::KIND_START, 16'h10 + i, 0, 0, i + 1, 10 * (i + 1), 0), 0, '0);
		add_row(rq(vca_pkg::KIND_START, 16'h99, 0, 0, 9, 255, 0), 1, '0);
		add_row(rq(vca_pkg::KIND_START, 16'h99, 0, 0, 9, 0, 0), 0, '0);
		add_row(rq(vca_pkg::KIND_START, 16'h11, 0, 0, 12, 40, 0), 0, '0);
		add_row(rq(vca_pkg::KIND_START, 16'h12, 1, 5, 13, 40, 0), 0, '0);
		add_row(rq(vca_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(rq(vca_pkg::KIND_START, 0, 1, 0, 14, 128, 0), 0, '0);
		add_row(rq(vca_pkg::KIND_STOP, 16'h13, 0, 12'h0a5, 0, 0, 0), 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			cfg = cfg_plan[ph];
			if (cfg == -1)
				cfg = $urandom_range(2, 7);
			else if (cfg == -2)
				cfg = $urandom_range(9, 14);
			set_voices(cfg[3:0]);
			idle_pct = idle_plan[ph];
			stall_pct = stall_plan[ph];
			for (int n = 0; n < items_plan[ph]; n++) begin
				if ($urandom_range(63) == 0)
					drain();
				send_request(random_req(), 0, '0);
			end
		end

		drain();
		idle_pct = 0;
		stall_pct = 0;
		repeat (20) @(posedge clk);
		$display("%0d requests checked over %0d voices_in_use settings and four pacing modes",
			requests_sent, settings_written);
		$display("%0d voices granted, %0d of them by same-origin reuse or stealing",
			grants_made, reuse_or_steal);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
design/vca_pkg.sv
design/vca_cell.sv
design/voice_channel_allocator.sv
tb/sv/voice_channel_allocator_test.sv
